@@ rtl/gbe_pkg.sv @@
// ----------------------------------------------------------------------------
// GOST block encryption package
// Shared types, constants and the S-box substitution for the round cells.
// ----------------------------------------------------------------------------
package gbe_pkg;

   localparam int ROUNDS    = 32;
   localparam int KEY_WORDS = 8;
   localparam int CSR_COUNT = 4;
   localparam int ADDR_W    = 5;

   typedef logic [31:0] gbe_word_type;

   // The whole key, word 0 in the lowest slot.
   typedef logic [KEY_WORDS-1:0][31:0] gbe_key_type;

   // One beat travelling along the chain of round cells.
   typedef struct packed {
      logic         valid;
      gbe_word_type a;   // half that feeds the round function
      gbe_word_type b;   // half that the round output is mixed into
   } gbe_beat_type;

   // Compressed S-box ROM: byte lane L uses entries 16L..16L+15.
   localparam logic [7:0] SBOX_ROM [64] = '{
      8'hE4, 8'hBA, 8'h49, 8'hC2, 8'h6D, 8'hD8, 8'hF0, 8'hAE,
      8'h26, 8'h3B, 8'h81, 8'h1C, 8'h07, 8'h7F, 8'h55, 8'h93,
      8'h75, 8'hD8, 8'hA1, 8'h1D, 8'h0A, 8'h83, 8'h94, 8'hF2,
      8'hEE, 8'h4F, 8'h6C, 8'hC7, 8'hB6, 8'h20, 8'h59, 8'h3B,
      8'h46, 8'hBC, 8'hA7, 8'h01, 8'h75, 8'h2F, 8'h1D, 8'hD8,
      8'h34, 8'h6A, 8'h89, 8'h5E, 8'h90, 8'hC3, 8'hFB, 8'hE2,
      8'h1D, 8'hFB, 8'hD4, 8'h01, 8'h53, 8'h7F, 8'hA5, 8'h49,
      8'h90, 8'h2A, 8'h3E, 8'hE7, 8'h66, 8'hB8, 8'h82, 8'hCC
   };

   // Replaces every nibble of the word through the S-box of its position.
   // The high nibble of a byte takes the upper nibble of its ROM entry,
   // the low nibble the lower one.
   function automatic gbe_word_type gbe_substitute(input gbe_word_type x);
      gbe_word_type res;
      logic [7:0]   byte_v;
      logic [7:0]   hi_e;
      logic [7:0]   lo_e;
      res = '0;
      for (int lane = 0; lane < 4; lane++) begin
         byte_v = x[8*lane +: 8];
         hi_e   = SBOX_ROM[{2'(lane), byte_v[7:4]}];
         lo_e   = SBOX_ROM[{2'(lane), byte_v[3:0]}];
         res[8*lane +: 8] = {hi_e[7:4], lo_e[3:0]};
      end
      return res;
   endfunction

   // Key schedule: words 0..7 three times, then 7..0.
   function automatic logic [2:0] gbe_key_index(input int round);
      logic [2:0] low;
      low = 3'(round);
      if (round < 3 * KEY_WORDS) begin
         return low;
      end
      return ~low;
   endfunction

endpackage

@@ rtl/gbe_round_cell.sv @@
// ----------------------------------------------------------------------------
// GOST round cell
// One Feistel round followed by a register; the halves swap on the way out.
// ----------------------------------------------------------------------------
module gbe_round_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  gbe_pkg::gbe_word_type key_word,
   input  gbe_pkg::gbe_beat_type beat_in,
   output gbe_pkg::gbe_beat_type beat_out
);
   import gbe_pkg::*;

   gbe_word_type sum;
   gbe_word_type sub;
   gbe_word_type rot;
   gbe_beat_type beat_ff_in;
   gbe_beat_type beat_ff;

   // Round function: key addition, substitution, rotate left by eleven.
   always_comb begin
      sum = beat_in.a + key_word;
      sub = gbe_substitute(sum);
      rot = {sub[20:0], sub[31:21]};
   end

   // Mix into the other half and swap, so the next cell sees the new half first.
   always_comb begin
      beat_ff_in.valid = beat_in.valid;
      beat_ff_in.a     = beat_in.b ^ rot;
      beat_ff_in.b     = beat_in.a;
   end

   // Stage register; only the valid bit needs reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_ff_in;
      end
   end

   assign beat_out = beat_ff;

endmodule

@@ rtl/gbe_csr.sv @@
// ----------------------------------------------------------------------------
// GOST key registers
// APB-style register file holding the 256-bit key as four 64-bit registers.
// ----------------------------------------------------------------------------
module gbe_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [gbe_pkg::ADDR_W-1:0] paddr,
   input  logic [63:0]               pwdata,
   output logic [63:0]               prdata,
   output logic                      pready,
   output gbe_pkg::gbe_key_type      key
);
   import gbe_pkg::*;

   logic [63:0] key_ff [CSR_COUNT];
   logic [1:0]  reg_index;
   logic        write_en;

   assign reg_index = paddr[ADDR_W-1:3];
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;

   // Register write on the access phase of a write beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_COUNT; i++) begin
            key_ff[i] <= '0;
         end
      end else if (write_en) begin
         key_ff[reg_index] <= pwdata;
      end
   end

   assign prdata = key_ff[reg_index];

   // Each register carries an even key word low and the odd one high.
   always_comb begin
      for (int i = 0; i < CSR_COUNT; i++) begin
         key[2*i]     = key_ff[i][31:0];
         key[2*i + 1] = key_ff[i][63:32];
      end
   end

endmodule

@@ rtl/gost_block_encrypt_core.sv @@
// An accepted block moves through the round cell registers in order to the result port.
// One block per cycle unless a result is held; the 32 round cells move as one pipeline.
// A held result stalls the whole chain, and the input is stalled in the same cycle.
// Reset clears every valid bit and the key registers; the key reads as zero until written.
// ----------------------------------------------------------------------------
// GOST 28147-89 block encryption core
// ECB encryption of 64-bit blocks through a chain of 32 round cells.
// ----------------------------------------------------------------------------
module gost_block_encrypt_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [31:0]               plain_low,
   input  logic [31:0]               plain_high,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [31:0]               cipher_low,
   output logic [31:0]               cipher_high,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [gbe_pkg::ADDR_W-1:0] paddr,
   input  logic [63:0]               pwdata,
   output logic [63:0]               prdata,
   output logic                      pready
);
   import gbe_pkg::*;

   gbe_key_type  key;
   gbe_beat_type beats [ROUNDS+1];
   logic         advance;

   // Key register file.
   gbe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .key     (key)
   );

   // The chain moves unless the last cell holds a result that is not taken.
   assign advance   = !(beats[ROUNDS].valid && rsp_stall);
   assign req_stall = !advance;

   // Input beat enters the first cell with N1 as the half fed to the round.
   always_comb begin
      beats[0].valid = req_valid;
      beats[0].a     = plain_low;
      beats[0].b     = plain_high;
   end

   // Row of round cells, each wired to its key word from the schedule.
   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      gbe_round_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .key_word (key[gbe_key_index(r)]),
         .beat_in  (beats[r]),
         .beat_out (beats[r+1])
      );
   end

   // The last cell is the output register; the closing swap is in the wiring.
   assign rsp_valid   = beats[ROUNDS].valid;
   assign cipher_low  = beats[ROUNDS].b;
   assign cipher_high = beats[ROUNDS].a;

endmodule

@@ rtl/gbe_checker.sv @@
// ----------------------------------------------------------------------------
// GOST core port checker
// Concurrent checks on the top-level ports, bound to the encryption core.
// ----------------------------------------------------------------------------
module gbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] cipher_low,
   input logic [31:0] cipher_high,
   input logic        pready
);

   // A stalled result beat stays and holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(cipher_low) && $stable(cipher_high))
      else $error("result beat changed while stalled");

   // The input is stalled exactly when a waiting result blocks the chain.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow the output stall");

   // No result straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // The register port never inserts wait states.
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("register port not ready");

endmodule

bind gost_block_encrypt_core gbe_checker u_gbe_checker (.*);

@@ test/gbe_block_checker.sv @@
// ----------------------------------------------------------------------------
// GOST block encryption checker
// Watches the block, key and result ports of the encryption core. It keeps
// its own copy of the key and its own cipher, predicts the ciphertext of
// every accepted block and compares it with the beats that come out.
// ----------------------------------------------------------------------------
module gbe_block_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [31:0]                plain_low,
   input  logic [31:0]                plain_high,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [31:0]                cipher_low,
   input  logic [31:0]                cipher_high,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic                       pready,
   input  logic [gbe_pkg::ADDR_W-1:0] paddr,
   input  logic [63:0]                pwdata,
   input  logic                       end_check,
   output int                         fail_count,
   output int                         pending_blocks,
   output int                         blocks_checked
);

   typedef struct packed {
      gbe_pkg::gbe_word_type low;
      gbe_pkg::gbe_word_type high;
   } cipher_block_type;

   // Eight 4-bit S-boxes packed two to a byte; byte lane L uses entries 16L..16L+15.
   localparam logic [7:0] SBOX_BYTES [64] = '{
      8'hE4, 8'hBA, 8'h49, 8'hC2, 8'h6D, 8'hD8, 8'hF0, 8'hAE,
      8'h26, 8'h3B, 8'h81, 8'h1C, 8'h07, 8'h7F, 8'h55, 8'h93,
      8'h75, 8'hD8, 8'hA1, 8'h1D, 8'h0A, 8'h83, 8'h94, 8'hF2,
      8'hEE, 8'h4F, 8'h6C, 8'hC7, 8'hB6, 8'h20, 8'h59, 8'h3B,
      8'h46, 8'hBC, 8'hA7, 8'h01, 8'h75, 8'h2F, 8'h1D, 8'hD8,
      8'h34, 8'h6A, 8'h89, 8'h5E, 8'h90, 8'hC3, 8'hFB, 8'hE2,
      8'h1D, 8'hFB, 8'hD4, 8'h01, 8'h53, 8'h7F, 8'hA5, 8'h49,
      8'h90, 8'h2A, 8'h3E, 8'hE7, 8'h66, 8'hB8, 8'h82, 8'hCC
   };

   gbe_pkg::gbe_word_type key_copy [gbe_pkg::KEY_WORDS];
   cipher_block_type      awaited_blocks [$];
   bit                    leftovers_reported;

   initial begin
      fail_count         = 0;
      pending_blocks     = 0;
      blocks_checked     = 0;
      leftovers_reported = 0;
      foreach (key_copy[i]) key_copy[i] = '0;
   end

   // One round: add the key word, substitute every nibble, rotate left by 11.
   function automatic gbe_pkg::gbe_word_type round_mix(input gbe_pkg::gbe_word_type half,
                                                       input gbe_pkg::gbe_word_type key_w);
      gbe_pkg::gbe_word_type sum;
      gbe_pkg::gbe_word_type sub;
      logic [7:0]            hi_entry;
      logic [7:0]            lo_entry;
      sum = half + key_w;
      sub = '0;
      for (int lane = 0; lane < 4; lane++) begin
         hi_entry = SBOX_BYTES[lane * 16 + sum[8*lane+4 +: 4]];
         lo_entry = SBOX_BYTES[lane * 16 + sum[8*lane +: 4]];
         sub[8*lane +: 8] = {hi_entry[7:4], lo_entry[3:0]};
      end
      return {sub[20:0], sub[31:21]};
   endfunction

   // Thirty-two rounds; key words run 0..7 three times and then 7..0.
   function automatic cipher_block_type encrypt_block(input gbe_pkg::gbe_word_type n1_in,
                                                      input gbe_pkg::gbe_word_type n2_in);
      gbe_pkg::gbe_word_type n1;
      gbe_pkg::gbe_word_type n2;
      gbe_pkg::gbe_word_type key_w;
      cipher_block_type      blk;
      n1 = n1_in;
      n2 = n2_in;
      for (int r = 0; r < gbe_pkg::ROUNDS; r++) begin
         key_w = (r < 24) ? key_copy[r % 8] : key_copy[31 - r];
         if (r % 2 == 0) begin
            n2 ^= round_mix(n1, key_w);
         end else begin
            n1 ^= round_mix(n2, key_w);
         end
      end
      // The halves leave the cipher swapped.
      blk.low  = n2;
      blk.high = n1;
      return blk;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < 30) begin
         $display("[%0t] checker: %s", $time, msg);
      end
      fail_count++;
   endtask

   // Sample every port at the rising edge, when the handshakes take effect.
   always @(posedge clock) begin
      cipher_block_type      wanted;
      int unsigned           reg_idx;
      reg_idx = paddr >> 3;
      if (reset) begin
         foreach (key_copy[i]) key_copy[i] = '0;
         awaited_blocks.delete();
      end else begin
         // Key register writes land in the local key copy.
         if (psel && penable && pwrite && pready && reg_idx < gbe_pkg::CSR_COUNT) begin
            key_copy[2 * reg_idx]     = pwdata[31:0];
            key_copy[2 * reg_idx + 1] = pwdata[63:32];
         end

         // A result beat is compared with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_blocks.size() == 0) begin
               report_mismatch($sformatf("result beat %h_%h with no block outstanding",
                                         cipher_high, cipher_low));
            end else begin
               wanted = awaited_blocks.pop_front();
               if (cipher_low !== wanted.low) begin
                  report_mismatch($sformatf("block %0d cipher_low %h, wanted %h",
                                            blocks_checked, cipher_low, wanted.low));
               end
               if (cipher_high !== wanted.high) begin
                  report_mismatch($sformatf("block %0d cipher_high %h, wanted %h",
                                            blocks_checked, cipher_high, wanted.high));
               end
            end
            blocks_checked++;
         end

         // An accepted plaintext beat yields one predicted ciphertext.
         if (req_valid && !req_stall) begin
            awaited_blocks.push_back(encrypt_block(plain_low, plain_high));
         end

         // At the end of the run nothing may still be awaited.
         if (end_check && !leftovers_reported) begin
            leftovers_reported = 1;
            if (awaited_blocks.size() != 0) begin
               report_mismatch($sformatf("%0d blocks never came out",
                                         awaited_blocks.size()));
            end
         end
      end
      pending_blocks = awaited_blocks.size();
   end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// GOST block encryption core testbench
// Drives plaintext blocks and key settings into the core with random gaps
// and result stalls, a stall-free stretch and a long result hold-off, and
// leaves prediction and comparison to the checker beside the core.
// ----------------------------------------------------------------------------
module tb;

   typedef enum int {
      KEY_REG_W01 = 0,
      KEY_REG_W23 = 1,
      KEY_REG_W45 = 2,
      KEY_REG_W67 = 3
   } key_reg_type;

   localparam int          IDLE_PERCENT   = 34;
   localparam int          HOLD_CYCLES    = 150;
   localparam int          PHASE_BLOCKS   = 75;
   localparam int          RANDOM_PHASES  = 6;
   localparam int          LATENCY        = 32;
   localparam int unsigned CYCLE_LIMIT    = 300000;

   // Corner blocks for the all-zero key, high word in 63:32.
   localparam logic [63:0] EDGE_BLOCKS [16] = '{
      64'h00000000_00000000, 64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_00000000,
      64'h00000000_FFFFFFFF, 64'hAAAAAAAA_55555555, 64'h55555555_AAAAAAAA,
      64'h00000000_00000001, 64'h00000001_00000000, 64'h00000000_80000000,
      64'h80000000_00000000, 64'h9ABCDEF0_12345678, 64'h76543210_FEDCBA98,
      64'hFFFF0000_0000FFFF, 64'hF0F0F0F0_0F0F0F0F, 64'h7FFFFFFF_7FFFFFFF,
      64'h80000000_80000000
   };

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [31:0]                plain_low;
   logic [31:0]                plain_high;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [31:0]                cipher_low;
   logic [31:0]                cipher_high;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [gbe_pkg::ADDR_W-1:0] paddr;
   logic [63:0]                pwdata;
   logic [63:0]                prdata;
   logic                       pready;
   logic                       end_check;

   int          fail_count;
   int          pending_blocks;
   int          blocks_checked;
   int          blocks_sent;
   int          key_settings;
   bit          no_idle;
   bit          hold_request;
   int unsigned cycle_count;

   gost_block_encrypt_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .plain_low   (plain_low),
      .plain_high  (plain_high),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cipher_low  (cipher_low),
      .cipher_high (cipher_high),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   gbe_block_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .plain_low      (plain_low),
      .plain_high     (plain_high),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .cipher_low     (cipher_low),
      .cipher_high    (cipher_high),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .end_check      (end_check),
      .fail_count     (fail_count),
      .pending_blocks (pending_blocks),
      .blocks_checked (blocks_checked)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a run that hangs ends here.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: random stalls, none in the stall-free stretch, and one long
   // hold-off counted here so that the pipeline fills and stalls its input.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // Mostly fully random blocks, with some all-zero/all-one halves and single bits.
   function automatic logic [63:0] random_block();
      case ($urandom_range(9))
         0: begin
            return {($urandom_range(1) ? 32'hFFFFFFFF : 32'h0),
                    ($urandom_range(1) ? 32'hFFFFFFFF : 32'h0)};
         end
         1: begin
            return {32'h1 << $urandom_range(31), 32'h1 << $urandom_range(31)};
         end
         default: begin
            return {$urandom, $urandom};
         end
      endcase
   endfunction

   // One key register write: setup cycle, then access cycle.
   task automatic write_key_reg(input key_reg_type idx, input logic [63:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= gbe_pkg::ADDR_W'(int'(idx) * 8);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_key(input logic [63:0] w01, input logic [63:0] w23,
                           input logic [63:0] w45, input logic [63:0] w67);
      write_key_reg(KEY_REG_W01, w01);
      write_key_reg(KEY_REG_W23, w23);
      write_key_reg(KEY_REG_W45, w45);
      write_key_reg(KEY_REG_W67, w67);
      key_settings++;
   endtask

   // Offer one plaintext beat after a random gap and hold it until accepted.
   task automatic send_block(input logic [63:0] blk);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      plain_low  <= blk[31:0];
      plain_high <= blk[63:32];
      do @(posedge clock); while (req_stall);
      blocks_sent++;
   endtask

   // Stop offering and wait until every ciphertext has come back.
   task automatic drain_blocks();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_blocks != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Stimulus and verdict.
   initial begin
      logic [63:0] keys [4];
      reset        = 1'b1;
      req_valid    = 1'b0;
      plain_low    = '0;
      plain_high   = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      end_check    = 1'b0;
      no_idle      = 0;
      hold_request = 0;
      blocks_sent  = 0;
      key_settings = 1;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Corner blocks under the reset key, which is all zero.
      foreach (EDGE_BLOCKS[i]) send_block(EDGE_BLOCKS[i]);
      drain_blocks();

      // All-ones key, so every key addition of a nonzero half wraps.
      load_key('1, '1, '1, '1);
      send_block(64'h00000000_00000000);
      send_block(64'hFFFFFFFF_FFFFFFFF);
      send_block(64'h00000000_FFFFFFFF);
      send_block(64'hFFFFFFFF_00000000);
      drain_blocks();

      // Random phases, each under its own key.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         foreach (keys[i]) keys[i] = {$urandom, $urandom};
         if (phase == 3) begin
            foreach (keys[i]) keys[i] = 64'hAAAAAAAA_55555555;
         end else if (phase == 4) begin
            foreach (keys[i]) keys[i] = '0;
         end
         load_key(keys[0], keys[1], keys[2], keys[3]);
         no_idle = (phase == 1);
         for (int n = 0; n < PHASE_BLOCKS; n++) begin
            if (phase == 2 && n == 10) hold_request = 1;
            send_block(random_block());
         end
         drain_blocks();
      end
      no_idle = 0;

      // Let any stray beat surface, then close the books.
      repeat (LATENCY + 8) @(negedge clock);
      end_check <= 1'b1;
      repeat (2) @(negedge clock);

      $display("Encrypted %0d blocks (%0d checked) under %0d key settings.",
               blocks_sent, blocks_checked, key_settings);
      $display("Covered random gaps and stalls, a stall-free stretch and a long hold-off.");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/gbe_pkg.sv
rtl/gbe_round_cell.sv
rtl/gbe_csr.sv
rtl/gost_block_encrypt_core.sv
rtl/gbe_checker.sv
test/gbe_block_checker.sv
test/tb.sv
